### hdl/rcsfd_pkg.sv
// Shared types and constants for the RC serial frame decoder with link failsafe.
`default_nettype none

package rcsfd_pkg;

	localparam int FRAME_LEN    = 16;
	localparam int NUM_CHANNELS = 16;
	localparam int PAIRS        = (FRAME_LEN - 2) / 2;

	localparam int FB_AW  = $clog2(FRAME_LEN);
	localparam int CT_AW  = $clog2(NUM_CHANNELS);
	localparam int CNT_W  = $clog2(FRAME_LEN + 1);
	localparam int PAIR_W = (PAIRS > 1) ? $clog2(PAIRS) : 1;
	localparam int WCNT_W = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DW    = 32;
	localparam int VAL_W     = 11;

	localparam logic [CFG_IDX_W-1:0] CFG_GAP_LIMIT      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_LIMIT     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FAILSAFE_LIMIT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_THROTTLE_SLOT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ROLL_SLOT      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PITCH_SLOT     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_YAW_SLOT       = 3'd6;

	localparam logic [31:0] GAP_LIMIT_RST      = 32'd2500;
	localparam logic [31:0] HOLD_LIMIT_RST     = 32'd100000;
	localparam logic [31:0] FAILSAFE_LIMIT_RST = 32'd1500000;
	localparam logic [CT_AW-1:0] THROTTLE_SLOT_RST = 4'd0;
	localparam logic [CT_AW-1:0] ROLL_SLOT_RST     = 4'd1;
	localparam logic [CT_AW-1:0] PITCH_SLOT_RST    = 4'd2;
	localparam logic [CT_AW-1:0] YAW_SLOT_RST      = 4'd3;

	localparam logic [1:0] REQ_BYTE  = 2'd0;
	localparam logic [1:0] REQ_CHECK = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	localparam logic [1:0] LS_OK   = 2'd0;
	localparam logic [1:0] LS_HOLD = 2'd1;
	localparam logic [1:0] LS_FAIL = 2'd2;

	localparam logic [WCNT_W-1:0] HOLD_LAST = 3'd2;
	localparam logic [WCNT_W-1:0] FAIL_LAST = 3'd7;

	localparam logic signed [VAL_W-1:0] FS_THROTTLE = -11'sd1000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_CHECK,
		ST_HOLD,
		ST_FAIL,
		ST_DEC,
		ST_DEC_LAST,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

### hdl/rc_serial_frame_decoder_failsafe_top.sv
// Top level of the RC serial frame decoder with link failsafe.
// A byte, a channel read, an unused request or a link check with no link goes straight to the result;
// a link check with a link adds a check and any hold or failsafe writes, a frame-ending byte the decode.
// One request is in flight at a time; the next is taken in the cycle after the result is registered.
// Decode and failsafe write the channel table one entry per cycle through its single write port.
// Reset clears the control state and the channel table valid bits and loads the configuration defaults.
`default_nettype none

module rc_serial_frame_decoder_failsafe_top (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [rcsfd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [rcsfd_pkg::CFG_DW-1:0]          cfg_wdata,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic [1:0]                            req_type,
	input  wire logic [31:0]                           time_now,
	input  wire logic [7:0]                            rx_byte,
	input  wire logic [rcsfd_pkg::CT_AW-1:0]           channel_index,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic [1:0]                                 link_status,
	output logic signed [rcsfd_pkg::VAL_W-1:0]         channel_value,
	output logic                                       frame_done
);

	rcsfd_pkg::state_t state_q, state_d;

	logic [31:0] gap_limit_q, hold_limit_q, failsafe_limit_q;
	logic [rcsfd_pkg::CT_AW-1:0] throttle_slot_q, roll_slot_q, pitch_slot_q, yaw_slot_q;

	logic [1:0]  req_q;
	logic [31:0] time_q;
	logic [7:0]  byte_q;
	logic [rcsfd_pkg::CT_AW-1:0] idx_q;

	logic [rcsfd_pkg::CNT_W-1:0]  cnt_q;
	logic                         ten_bit_q;
	logic                         link_valid_q;
	logic [31:0]                  last_byte_time_q, last_frame_time_q, dur_q;
	logic [rcsfd_pkg::PAIR_W-1:0] pair_q;
	logic [rcsfd_pkg::WCNT_W-1:0] wcnt_q;
	logic [1:0]                   res_status_q;
	logic                         res_done_q;

	logic                               out_valid_q, frame_done_q;
	logic [1:0]                         link_status_q;
	logic signed [rcsfd_pkg::VAL_W-1:0] channel_value_q;

	logic [7:0] fb_mem [rcsfd_pkg::FRAME_LEN];
	logic [7:0] fb_rd_a_s1, fb_rd_b_s1;
	logic [rcsfd_pkg::VAL_W-1:0] ct_mem [rcsfd_pkg::NUM_CHANNELS];
	logic [rcsfd_pkg::NUM_CHANNELS-1:0] ct_vld_q;
	logic [rcsfd_pkg::VAL_W-1:0] ct_rd_q;
	logic                        ct_rd_vld_q;

	logic        accept, out_free;
	logic [31:0] gap;
	logic        restart, frame_full;
	logic [rcsfd_pkg::CNT_W-1:0] cnt_base, cnt_next;
	logic [rcsfd_pkg::CT_AW-1:0] dec_slot;
	logic signed [rcsfd_pkg::VAL_W-1:0] dec_val;

	logic                               fb_we;
	logic [rcsfd_pkg::FB_AW-1:0]        fb_wa, fb_ra_a, fb_ra_b;
	logic                               ct_we, ct_re;
	logic [rcsfd_pkg::CT_AW-1:0]        ct_wa;
	logic signed [rcsfd_pkg::VAL_W-1:0] ct_wd;

	assign in_stall = (state_q != rcsfd_pkg::ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign gap        = time_q - last_byte_time_q;
	assign restart    = (gap > gap_limit_q) ||
	                    (cnt_q >= rcsfd_pkg::CNT_W'(rcsfd_pkg::FRAME_LEN));
	assign cnt_base   = restart ? '0 : cnt_q;
	assign cnt_next   = cnt_base + rcsfd_pkg::CNT_W'(1);
	assign frame_full = (cnt_next == rcsfd_pkg::CNT_W'(rcsfd_pkg::FRAME_LEN));

	// Subtracting the code offset only inverts the top bit of the masked word.
	always_comb begin
		if (ten_bit_q) begin
			dec_slot = fb_rd_a_s1[5:2];
			dec_val  = {~fb_rd_a_s1[1], fb_rd_a_s1[0], fb_rd_b_s1, 1'b0};
		end else begin
			dec_slot = fb_rd_a_s1[6:3];
			dec_val  = {~fb_rd_a_s1[2], fb_rd_a_s1[1:0], fb_rd_b_s1};
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			rcsfd_pkg::ST_IDLE: begin
				if (in_valid) state_d = rcsfd_pkg::ST_EXEC;
			end
			rcsfd_pkg::ST_EXEC: begin
				case (req_q)
					rcsfd_pkg::REQ_BYTE:
						state_d = frame_full ? rcsfd_pkg::ST_DEC : rcsfd_pkg::ST_DONE;
					rcsfd_pkg::REQ_CHECK:
						state_d = link_valid_q ? rcsfd_pkg::ST_CHECK : rcsfd_pkg::ST_DONE;
					default: state_d = rcsfd_pkg::ST_DONE;
				endcase
			end
			rcsfd_pkg::ST_CHECK: begin
				if (dur_q < hold_limit_q) state_d = rcsfd_pkg::ST_DONE;
				else if (dur_q < failsafe_limit_q) state_d = rcsfd_pkg::ST_HOLD;
				else state_d = rcsfd_pkg::ST_FAIL;
			end
			rcsfd_pkg::ST_HOLD: begin
				if (wcnt_q == rcsfd_pkg::HOLD_LAST) state_d = rcsfd_pkg::ST_DONE;
			end
			rcsfd_pkg::ST_FAIL: begin
				if (wcnt_q == rcsfd_pkg::FAIL_LAST) state_d = rcsfd_pkg::ST_DONE;
			end
			rcsfd_pkg::ST_DEC: begin
				if (pair_q == rcsfd_pkg::PAIR_W'(rcsfd_pkg::PAIRS - 1))
					state_d = rcsfd_pkg::ST_DEC_LAST;
			end
			rcsfd_pkg::ST_DEC_LAST: state_d = rcsfd_pkg::ST_DONE;
			rcsfd_pkg::ST_DONE: begin
				if (out_free) state_d = rcsfd_pkg::ST_IDLE;
			end
			default: state_d = rcsfd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		fb_we   = 1'b0;
		fb_wa   = cnt_base[rcsfd_pkg::FB_AW-1:0];
		fb_ra_a = rcsfd_pkg::FB_AW'({pair_q, 1'b0}) + rcsfd_pkg::FB_AW'(2);
		fb_ra_b = rcsfd_pkg::FB_AW'({pair_q, 1'b0}) + rcsfd_pkg::FB_AW'(3);
		ct_we   = 1'b0;
		ct_re   = 1'b0;
		ct_wa   = dec_slot;
		ct_wd   = dec_val;
		case (state_q)
			rcsfd_pkg::ST_EXEC: begin
				fb_we = (req_q == rcsfd_pkg::REQ_BYTE);
				ct_re = (req_q == rcsfd_pkg::REQ_READ);
			end
			rcsfd_pkg::ST_DEC: begin
				ct_we = (pair_q != '0);
			end
			rcsfd_pkg::ST_DEC_LAST: begin
				ct_we = 1'b1;
			end
			rcsfd_pkg::ST_HOLD: begin
				ct_we = 1'b1;
				ct_wd = '0;
				if (wcnt_q == '0) ct_wa = roll_slot_q;
				else if (wcnt_q == rcsfd_pkg::WCNT_W'(1)) ct_wa = pitch_slot_q;
				else ct_wa = yaw_slot_q;
			end
			rcsfd_pkg::ST_FAIL: begin
				ct_we = 1'b1;
				if (wcnt_q == rcsfd_pkg::FAIL_LAST) begin
					ct_wa = throttle_slot_q;
					ct_wd = rcsfd_pkg::FS_THROTTLE;
				end else begin
					ct_wa = rcsfd_pkg::CT_AW'(wcnt_q) + rcsfd_pkg::CT_AW'(1);
					ct_wd = '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_limit_q      <= rcsfd_pkg::GAP_LIMIT_RST;
			hold_limit_q     <= rcsfd_pkg::HOLD_LIMIT_RST;
			failsafe_limit_q <= rcsfd_pkg::FAILSAFE_LIMIT_RST;
			throttle_slot_q  <= rcsfd_pkg::THROTTLE_SLOT_RST;
			roll_slot_q      <= rcsfd_pkg::ROLL_SLOT_RST;
			pitch_slot_q     <= rcsfd_pkg::PITCH_SLOT_RST;
			yaw_slot_q       <= rcsfd_pkg::YAW_SLOT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				rcsfd_pkg::CFG_GAP_LIMIT:      gap_limit_q      <= cfg_wdata;
				rcsfd_pkg::CFG_HOLD_LIMIT:     hold_limit_q     <= cfg_wdata;
				rcsfd_pkg::CFG_FAILSAFE_LIMIT: failsafe_limit_q <= cfg_wdata;
				rcsfd_pkg::CFG_THROTTLE_SLOT:  throttle_slot_q  <= cfg_wdata[rcsfd_pkg::CT_AW-1:0];
				rcsfd_pkg::CFG_ROLL_SLOT:      roll_slot_q      <= cfg_wdata[rcsfd_pkg::CT_AW-1:0];
				rcsfd_pkg::CFG_PITCH_SLOT:     pitch_slot_q     <= cfg_wdata[rcsfd_pkg::CT_AW-1:0];
				rcsfd_pkg::CFG_YAW_SLOT:       yaw_slot_q       <= cfg_wdata[rcsfd_pkg::CT_AW-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= req_type;
			time_q <= time_now;
			byte_q <= rx_byte;
			idx_q  <= channel_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= rcsfd_pkg::ST_IDLE;
			cnt_q             <= '0;
			ten_bit_q         <= 1'b0;
			link_valid_q      <= 1'b0;
			last_byte_time_q  <= '0;
			last_frame_time_q <= '0;
			dur_q             <= '0;
			pair_q            <= '0;
			wcnt_q            <= '0;
			res_status_q      <= rcsfd_pkg::LS_OK;
			res_done_q        <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				rcsfd_pkg::ST_IDLE: begin
					if (accept) begin
						res_status_q <= rcsfd_pkg::LS_OK;
						res_done_q   <= 1'b0;
					end
				end
				rcsfd_pkg::ST_EXEC: begin
					if (req_q == rcsfd_pkg::REQ_BYTE) begin
						last_byte_time_q <= time_q;
						if (cnt_base == rcsfd_pkg::CNT_W'(1)) ten_bit_q <= byte_q[4];
						if (frame_full) begin
							cnt_q             <= '0;
							link_valid_q      <= 1'b1;
							last_frame_time_q <= time_q;
							res_done_q        <= 1'b1;
							pair_q            <= '0;
						end else begin
							cnt_q <= cnt_next;
						end
					end else if (req_q == rcsfd_pkg::REQ_CHECK) begin
						dur_q <= time_q - last_frame_time_q;
						if (!link_valid_q) res_status_q <= rcsfd_pkg::LS_FAIL;
					end
				end
				rcsfd_pkg::ST_CHECK: begin
					wcnt_q <= '0;
					if (dur_q < hold_limit_q) begin
						res_status_q <= rcsfd_pkg::LS_OK;
					end else if (dur_q < failsafe_limit_q) begin
						res_status_q <= rcsfd_pkg::LS_HOLD;
					end else begin
						res_status_q <= rcsfd_pkg::LS_FAIL;
						link_valid_q <= 1'b0;
					end
				end
				rcsfd_pkg::ST_HOLD, rcsfd_pkg::ST_FAIL: begin
					wcnt_q <= wcnt_q + rcsfd_pkg::WCNT_W'(1);
				end
				rcsfd_pkg::ST_DEC: begin
					pair_q <= pair_q + rcsfd_pkg::PAIR_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fb_we) fb_mem[fb_wa] <= byte_q;
		fb_rd_a_s1 <= fb_mem[fb_ra_a];
		fb_rd_b_s1 <= fb_mem[fb_ra_b];
	end

	always_ff @(posedge clk) begin
		if (ct_we) ct_mem[ct_wa] <= ct_wd;
		if (ct_re) ct_rd_q <= ct_mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ct_vld_q    <= '0;
			ct_rd_vld_q <= 1'b0;
		end else begin
			if (ct_we) ct_vld_q[ct_wa] <= 1'b1;
			if (ct_re) ct_rd_vld_q <= ct_vld_q[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == rcsfd_pkg::ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rcsfd_pkg::ST_DONE && out_free) begin
			link_status_q   <= res_status_q;
			frame_done_q    <= res_done_q;
			channel_value_q <= (req_q == rcsfd_pkg::REQ_READ && ct_rd_vld_q) ?
			                   ct_rd_q : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign link_status   = link_status_q;
	assign frame_done    = frame_done_q;
	assign channel_value = channel_value_q;

	a_cnt_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < rcsfd_pkg::CNT_W'(rcsfd_pkg::FRAME_LEN))
		else $error("byte count left the frame range");

	a_dec_end_state: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rcsfd_pkg::ST_DEC_LAST) |-> (cnt_q == '0 && link_valid_q && res_done_q))
		else $error("frame decode without restarted count and valid link");

	a_ct_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ct_we && ct_re))
		else $error("channel table read and written in the same cycle");

	a_done_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rcsfd_pkg::ST_DONE && out_valid_q && out_stall) |=>
		(state_q == rcsfd_pkg::ST_DONE && out_valid_q))
		else $error("result left while the output register was still held");

endmodule

`default_nettype wire

### test/tb_top.sv
// Self-checking testbench for the RC serial frame decoder with link failsafe.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] REQ_SPARE = 2'd3;

	typedef struct {
		logic [1:0]                  kind;
		logic [31:0]                 stamp;
		logic [7:0]                  octet;
		logic [rcsfd_pkg::CT_AW-1:0] entry;
	} request_t;

	typedef struct {
		logic [1:0]                         status;
		logic signed [rcsfd_pkg::VAL_W-1:0] value;
		logic                               done;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [rcsfd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [rcsfd_pkg::CFG_DW-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] req_type = '0;
	logic [31:0] time_now = '0;
	logic [7:0] rx_byte = '0;
	logic [rcsfd_pkg::CT_AW-1:0] channel_index = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] link_status;
	logic signed [rcsfd_pkg::VAL_W-1:0] channel_value;
	logic frame_done;

	rc_serial_frame_decoder_failsafe_top dut (.*);

	always #5 clk = ~clk;

	logic [31:0] gap_lim = rcsfd_pkg::GAP_LIMIT_RST;
	logic [31:0] hold_lim = rcsfd_pkg::HOLD_LIMIT_RST;
	logic [31:0] fs_lim = rcsfd_pkg::FAILSAFE_LIMIT_RST;
	logic [rcsfd_pkg::CT_AW-1:0] thr_slot = rcsfd_pkg::THROTTLE_SLOT_RST;
	logic [rcsfd_pkg::CT_AW-1:0] roll_idx = rcsfd_pkg::ROLL_SLOT_RST;
	logic [rcsfd_pkg::CT_AW-1:0] pitch_idx = rcsfd_pkg::PITCH_SLOT_RST;
	logic [rcsfd_pkg::CT_AW-1:0] yaw_idx = rcsfd_pkg::YAW_SLOT_RST;

	logic [7:0] frame_buf [rcsfd_pkg::FRAME_LEN] = '{default: '0};
	int nbytes = 0;
	logic signed [rcsfd_pkg::VAL_W-1:0] chan_tab [rcsfd_pkg::NUM_CHANNELS] = '{default: '0};
	logic link_up = 1'b0;
	logic [31:0] last_rx_t = '0;
	logic [31:0] last_frame_t = '0;

	request_t rx_requests [$];
	answer_t predicted_answers [$];
	request_t on_wire;
	answer_t want;
	int queued_cnt = 0;
	int accepted_cnt = 0;
	int mismatch_count = 0;

	logic [31:0] gen_t = '0;
	logic [31:0] gen_frame_t = '0;
	int gen_cnt = 0;

	function automatic answer_t decode_request(request_t r);
		answer_t res;
		logic [31:0] gap;
		logic [31:0] dur;
		logic [7:0] c1;
		logic [15:0] w;
		logic [rcsfd_pkg::CT_AW-1:0] slot;
		logic ten;
		int v;
		res = '{status: rcsfd_pkg::LS_OK, value: '0, done: 1'b0};
		case (r.kind)
			rcsfd_pkg::REQ_BYTE: begin
				gap = r.stamp - last_rx_t;
				last_rx_t = r.stamp;
				if (gap > gap_lim)
					nbytes = 0;
				if (nbytes >= rcsfd_pkg::FRAME_LEN)
					nbytes = 0;
				frame_buf[nbytes] = r.octet;
				nbytes++;
				if (nbytes == rcsfd_pkg::FRAME_LEN) begin
					ten = frame_buf[1][4];
					for (int p = 0; p < rcsfd_pkg::PAIRS; p++) begin
						c1 = frame_buf[2 + 2 * p];
						w = {c1, frame_buf[3 + 2 * p]};
						if (ten) begin
							slot = c1[5:2];
							v = (int'(w[9:0]) - 512) * 2;
						end else begin
							slot = c1[6:3];
							v = int'(w[10:0]) - 1024;
						end
						chan_tab[slot] = v[rcsfd_pkg::VAL_W-1:0];
					end
					link_up = 1'b1;
					last_frame_t = r.stamp;
					nbytes = 0;
					res.done = 1'b1;
				end
			end
			rcsfd_pkg::REQ_CHECK: begin
				if (!link_up) begin
					res.status = rcsfd_pkg::LS_FAIL;
				end else begin
					dur = r.stamp - last_frame_t;
					if (dur < hold_lim) begin
						res.status = rcsfd_pkg::LS_OK;
					end else if (dur < fs_lim) begin
						chan_tab[roll_idx] = '0;
						chan_tab[pitch_idx] = '0;
						chan_tab[yaw_idx] = '0;
						res.status = rcsfd_pkg::LS_HOLD;
					end else begin
						link_up = 1'b0;
						for (int i = 1; i < 8; i++)
							chan_tab[i] = '0;
						chan_tab[thr_slot] = rcsfd_pkg::FS_THROTTLE;
						res.status = rcsfd_pkg::LS_FAIL;
					end
				end
			end
			rcsfd_pkg::REQ_READ: begin
				res.value = chan_tab[r.entry];
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : sender
		int burst_left;
		int idle_left;
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left = 1;
			idle_left = 0;
		end else begin
			if (in_valid && !in_stall) begin
				predicted_answers.push_back(decode_request(on_wire));
				accepted_cnt++;
			end
			if (!in_valid || !in_stall) begin
				if (idle_left > 0) begin
					idle_left--;
					in_valid <= 1'b0;
				end else if (rx_requests.size() > 0) begin
					on_wire = rx_requests.pop_front();
					in_valid <= 1'b1;
					req_type <= on_wire.kind;
					time_now <= on_wire.stamp;
					rx_byte <= on_wire.octet;
					channel_index <= on_wire.entry;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 24);
						idle_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : receiver
		int rx_cyc;
		int hold_left;
		int stall_mode;
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_cyc = 0;
			hold_left = 0;
			stall_mode = 0;
		end else begin
			rx_cyc++;
			if (rx_cyc % 64 == 0)
				stall_mode = $urandom_range(0, 3);
			if (rx_cyc % 5000 == 700)
				hold_left = 300;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				case (stall_mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 1) == 0);
					default: out_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (predicted_answers.size() == 0) begin
				$error("unexpected result: link_status %0d channel_value %0d frame_done %0d",
					link_status, channel_value, frame_done);
				mismatch_count++;
			end else begin
				want = predicted_answers.pop_front();
				if (link_status !== want.status) begin
					$error("link_status: expected %0d, got %0d", want.status, link_status);
					mismatch_count++;
				end
				if (channel_value !== want.value) begin
					$error("channel_value: expected %0d, got %0d", want.value, channel_value);
					mismatch_count++;
				end
				if (frame_done !== want.done) begin
					$error("frame_done: expected %0d, got %0d", want.done, frame_done);
					mismatch_count++;
				end
			end
		end
	end

	task automatic push_req(input logic [1:0] kind, input logic [31:0] t, input logic [7:0] b,
		input logic [rcsfd_pkg::CT_AW-1:0] idx);
		rx_requests.push_back('{kind: kind, stamp: t, octet: b, entry: idx});
		queued_cnt++;
	endtask

	function automatic logic [31:0] byte_step();
		logic [31:0] cap;
		cap = (gap_lim < 32'd3000) ? gap_lim : 32'd3000;
		if ($urandom_range(0, 7) == 0)
			return cap;
		return $urandom_range(0, cap);
	endfunction

	function automatic logic [31:0] pick_dur();
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return hold_lim - 1;
			2: return hold_lim;
			3: return fs_lim - 1;
			4: return fs_lim;
			5: return $urandom;
			6: return $urandom_range(0, hold_lim);
			default: return $urandom_range(hold_lim, fs_lim);
		endcase
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic [31:0] step);
		gen_t += step;
		if (step > gap_lim)
			gen_cnt = 0;
		gen_cnt++;
		if (gen_cnt == rcsfd_pkg::FRAME_LEN) begin
			gen_cnt = 0;
			gen_frame_t = gen_t;
		end
		push_req(rcsfd_pkg::REQ_BYTE, gen_t, b, rcsfd_pkg::CT_AW'($urandom));
	endtask

	task automatic send_aside();
		if ($urandom_range(0, 1) == 0)
			push_req(rcsfd_pkg::REQ_CHECK, gen_frame_t + pick_dur(), 8'($urandom),
				rcsfd_pkg::CT_AW'($urandom));
		else
			push_req(rcsfd_pkg::REQ_READ, $urandom, 8'($urandom),
				rcsfd_pkg::CT_AW'($urandom));
	endtask

	task automatic send_frame(input logic ten);
		logic [7:0] b;
		logic [31:0] first_step;
		if (gen_cnt != 0) begin
			if (gap_lim == '1) begin
				while (gen_cnt != 0)
					send_byte(8'($urandom), byte_step());
				first_step = byte_step();
			end else begin
				first_step = gap_lim + 1 +
					((gap_lim < 32'h8000_0000) ? $urandom_range(0, 1000) : 0);
			end
		end else begin
			first_step = byte_step();
		end
		for (int k = 0; k < rcsfd_pkg::FRAME_LEN; k++) begin
			b = 8'($urandom);
			if (k == 1)
				b[4] = ten;
			else if (k >= 2 && $urandom_range(0, 7) == 0)
				b = ($urandom_range(0, 1) == 0) ? 8'hFF : 8'h00;
			send_byte(b, (k == 0) ? first_step : byte_step());
			if (k < rcsfd_pkg::FRAME_LEN - 1 && $urandom_range(0, 9) == 0)
				send_aside();
		end
	endtask

	task automatic apply_settings(input logic [31:0] g, h, f, input logic [3:0] t, r, p, y);
		logic [rcsfd_pkg::CFG_DW-1:0] vals [7];
		logic [rcsfd_pkg::CFG_IDX_W-1:0] regs [7];
		logic [3:0] slots [4];
		vals[0] = g;
		vals[1] = h;
		vals[2] = f;
		slots = '{t, r, p, y};
		for (int i = 0; i < 4; i++) begin
			vals[3 + i] = $urandom;
			vals[3 + i][3:0] = slots[i];
		end
		regs = '{rcsfd_pkg::CFG_GAP_LIMIT, rcsfd_pkg::CFG_HOLD_LIMIT,
			rcsfd_pkg::CFG_FAILSAFE_LIMIT, rcsfd_pkg::CFG_THROTTLE_SLOT,
			rcsfd_pkg::CFG_ROLL_SLOT, rcsfd_pkg::CFG_PITCH_SLOT, rcsfd_pkg::CFG_YAW_SLOT};
		for (int i = 0; i < 7; i++) begin
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_index <= regs[i];
			cfg_wdata <= vals[i];
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		gap_lim = g;
		hold_lim = h;
		fs_lim = f;
		thr_slot = t;
		roll_idx = r;
		pitch_idx = p;
		yaw_idx = y;
	endtask

	task automatic settle();
		while (accepted_cnt != queued_cnt || predicted_answers.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	initial begin
		#8_000_000;
		$display("rc_serial_frame_decoder_failsafe_top regression: fail");
		$finish;
	end

	initial begin
		int sel;
		int mark;
		logic [31:0] h;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Before any frame the link is down and the table reads zero.
		push_req(rcsfd_pkg::REQ_CHECK, $urandom, 8'($urandom), rcsfd_pkg::CT_AW'($urandom));
		push_req(REQ_SPARE, '1, '1, '1);
		push_req(rcsfd_pkg::REQ_READ, $urandom, 8'($urandom), 4'hF);
		send_byte(8'h00, byte_step());
		send_byte(8'h10, byte_step());
		send_byte(8'h00, byte_step());
		send_byte(8'h00, byte_step());
		send_byte(8'hFF, byte_step());
		send_byte(8'hFF, byte_step());
		repeat (rcsfd_pkg::FRAME_LEN - 6) send_byte(8'($urandom), byte_step());
		push_req(rcsfd_pkg::REQ_CHECK, gen_frame_t, 8'($urandom),
			rcsfd_pkg::CT_AW'($urandom));
		push_req(rcsfd_pkg::REQ_READ, $urandom, 8'($urandom), 4'hF);
		push_req(rcsfd_pkg::REQ_CHECK, gen_frame_t + hold_lim, 8'($urandom),
			rcsfd_pkg::CT_AW'($urandom));
		push_req(rcsfd_pkg::REQ_CHECK, gen_frame_t + fs_lim, 8'($urandom),
			rcsfd_pkg::CT_AW'($urandom));
		push_req(rcsfd_pkg::REQ_READ, $urandom, 8'($urandom), 4'h0);
		settle();

		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: apply_settings(32'd0, 32'd10, 32'd20, 4'd5, 4'd15, 4'd0, 4'd7);
				1: apply_settings('1, '1, '1, 4'd15, 4'd15, 4'd15, 4'd15);
				2: apply_settings(32'd2500, 32'd0, 32'd0, 4'd0, 4'd1, 4'd2, 4'd3);
				3: apply_settings(32'd100, 32'd5000, 32'd1000, 4'd3, 4'd3, 4'd9, 4'd12);
				default: begin
					h = $urandom_range(0, 200000);
					apply_settings($urandom_range(1, 3000), h, h + $urandom_range(0, 2000000),
						4'($urandom), 4'($urandom), 4'($urandom), 4'($urandom));
				end
			endcase
			if (ph == 6)
				send_byte(8'($urandom), 32'hFFFF_F000 - gen_t);
			mark = queued_cnt;
			while (queued_cnt - mark < 190) begin
				sel = $urandom_range(0, 19);
				if (sel < 12) begin
					send_frame(1'($urandom_range(0, 1)));
				end else if (sel < 17) begin
					send_aside();
				end else if (sel == 17) begin
					push_req(REQ_SPARE, $urandom, 8'($urandom), rcsfd_pkg::CT_AW'($urandom));
				end else begin
					repeat ($urandom_range(1, 20))
						send_byte(8'($urandom),
							($urandom_range(0, 1) == 0) ? byte_step() : $urandom);
				end
			end
			settle();
		end

		if (mismatch_count == 0 && predicted_answers.size() == 0)
			$display("rc_serial_frame_decoder_failsafe_top regression: pass");
		else
			$display("rc_serial_frame_decoder_failsafe_top regression: fail");
		$finish;
	end

endmodule
